@@ src/stun_attribute_tlv_parser_macros.svh @@
// Assertion macros shared by the STUN attribute parser RTL.
`ifndef STUN_ATTRIBUTE_TLV_PARSER_MACROS_SVH
`define STUN_ATTRIBUTE_TLV_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define STUN_TLV_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("STUN parser same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define STUN_TLV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("STUN parser next-cycle check failed");

`else

`define STUN_TLV_ASSERT_SAME(label, clk, rst, ante, cons)
`define STUN_TLV_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ src/stun_tlv_pkg.sv @@
// Types, constants and helpers for the STUN attribute parser.
package stun_tlv_pkg;

  // Walker phase; the codes double as the byte kind reported per byte.
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TYPE    = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_VALUE   = 3'd3,
    PH_PAD     = 3'd4,
    PH_OUTSIDE = 3'd5
  } phase_t;

  // Configuration port: 32-bit data, one 16-bit register at byte address 0.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] REG_WATCH_ATTR_TYPE = 1'b0;

  // Last header byte position.
  localparam logic [4:0] HEADER_LAST = 5'd19;
  // Header positions that carry the body length.
  localparam logic [4:0] HEADER_LEN_HI = 5'd2;
  localparam logic [4:0] HEADER_LEN_LO = 5'd3;

  // Attribute value length rounded up to a 4-byte boundary.
  function automatic logic [16:0] padded_len(input logic [15:0] len);
    logic [16:0] sum;
    sum = {1'b0, len} + 17'd3;
    return {sum[16:2], 2'b00};
  endfunction

endpackage

@@ src/stun_attribute_tlv_parser.sv @@
// STUN message attribute parser: header and TLV walker with per-byte tags.
`include "stun_attribute_tlv_parser_macros.svh"

// Takes a STUN message one byte per request and returns one tagged result per
// byte: its role (header, attribute type, length, value, padding or outside a
// message), header position, attribute ordinal, type, length, value offset,
// a match flag against the watch register, the body length from header bytes
// 2 and 3, and end-of-attribute, end-of-message and overrun flags.
// start_message on a byte begins a new message at header byte 0.
// A byte is accepted in every clock cycle while the result side keeps up. A
// byte passes through the input register and then the result register; the
// walker state is updated on the single pass between the input register and
// the result register. The input stalls only while both registers are full
// and the result is stalled, so a stalled result holds back one more byte.
// The watch register is written over the APB port at address 0.
module stun_attribute_tlv_parser (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [stun_tlv_pkg::PADDR_W-1:0]     paddr,
  input  logic [stun_tlv_pkg::PDATA_W-1:0]     pwdata,
  output logic [stun_tlv_pkg::PDATA_W-1:0]     prdata,
  output logic                                 pready,
  // Byte input channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           data_byte,
  input  logic                                 start_message,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [2:0]                           byte_kind,
  output logic [4:0]                           header_offset,
  output logic [7:0]                           attr_index,
  output logic [15:0]                          attr_kind,
  output logic [15:0]                          attr_length,
  output logic [15:0]                          value_offset,
  output logic [7:0]                           byte_out,
  output logic                                 type_match,
  output logic [15:0]                          message_length,
  output logic                                 attr_done,
  output logic                                 message_done,
  output logic                                 overrun_error
);
  import stun_tlv_pkg::*;

  // Configuration register.
  logic [15:0] watch_attr_type;

  // Input register.
  logic        iq_valid;
  logic [7:0]  iq_byte;
  logic        iq_start;

  // Walker state.
  phase_t      phase, phase_next;
  logic [4:0]  header_count, header_count_next;
  logic [15:0] body_length, body_length_next;
  logic [15:0] body_consumed, body_consumed_next;
  logic [15:0] current_type, current_type_next;
  logic [15:0] current_length, current_length_next;
  logic [15:0] field_count, field_count_next;
  logic [7:0]  attribute_count, attribute_count_next;
  logic        overrun_seen, overrun_seen_next;

  // Result computed for the byte in the input register.
  logic [2:0]  res_kind;
  logic [4:0]  res_hoff;
  logic [7:0]  res_index;
  logic [15:0] res_type;
  logic [15:0] res_len;
  logic [15:0] res_voff;
  logic        res_match;
  logic [15:0] res_msg_len;
  logic        res_adone;
  logic        res_mdone;
  logic        res_overrun;

  logic advance;
  logic step;
  logic cfg_write;

  // The result register takes a new result when empty or being drained.
  assign advance  = !out_valid || !out_stall;
  assign step     = iq_valid && advance;
  assign in_stall = iq_valid && !advance;

  // APB register access; writes land on the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[PADDR_W-1:2] == REG_WATCH_ATTR_TYPE) ?
                     {{(PDATA_W-16){1'b0}}, watch_attr_type} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      watch_attr_type <= '0;
    end else if (cfg_write && paddr[PADDR_W-1:2] == REG_WATCH_ATTR_TYPE) begin
      watch_attr_type <= pwdata[15:0];
    end
  end

  // Input register: holds one byte request until the walker takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      iq_valid <= 1'b0;
    end else if (!in_stall) begin
      iq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      iq_byte  <= data_byte;
      iq_start <= start_message;
    end
  end

  // Walker state register, updated once per byte that moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_OUTSIDE;
      header_count    <= '0;
      body_length     <= '0;
      body_consumed   <= '0;
      current_type    <= '0;
      current_length  <= '0;
      field_count     <= '0;
      attribute_count <= '0;
      overrun_seen    <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      body_length     <= body_length_next;
      body_consumed   <= body_consumed_next;
      current_type    <= current_type_next;
      current_length  <= current_length_next;
      field_count     <= field_count_next;
      attribute_count <= attribute_count_next;
      overrun_seen    <= overrun_seen_next;
    end
  end

  // Next state and result for the byte in the input register.
  always_comb begin
    phase_t      ph;
    logic [4:0]  hc;
    logic [15:0] bl;
    logic [15:0] bc;
    logic [15:0] ct;
    logic [15:0] cl;
    logic [15:0] fc;
    logic [7:0]  ac;
    logic        ov;
    logic [16:0] consumed;
    logic [16:0] fc_inc;
    logic [17:0] reach;
    logic        type_known;

    // A start byte drops the message in progress before it is walked.
    ph = iq_start ? PH_HEADER : phase;
    hc = iq_start ? 5'd0  : header_count;
    bl = iq_start ? 16'd0 : body_length;
    bc = iq_start ? 16'd0 : body_consumed;
    ct = iq_start ? 16'd0 : current_type;
    cl = iq_start ? 16'd0 : current_length;
    fc = iq_start ? 16'd0 : field_count;
    ac = iq_start ? 8'd0  : attribute_count;
    ov = iq_start ? 1'b0  : overrun_seen;

    consumed   = {1'b0, bc} + 17'd1;
    fc_inc     = {1'b0, fc} + 17'd1;
    reach      = '0;
    type_known = 1'b1;

    phase_next           = ph;
    header_count_next    = hc;
    body_length_next     = bl;
    body_consumed_next   = bc;
    current_type_next    = ct;
    current_length_next  = cl;
    field_count_next     = fc;
    attribute_count_next = ac;
    overrun_seen_next    = ov;

    res_kind    = PH_OUTSIDE;
    res_hoff    = '0;
    res_index   = '0;
    res_type    = '0;
    res_len     = '0;
    res_voff    = '0;
    res_match   = 1'b0;
    res_msg_len = bl;
    res_adone   = 1'b0;
    res_mdone   = 1'b0;
    res_overrun = 1'b0;

    case (ph)
      PH_HEADER: begin
        // Header bytes: latch the body length, leave at byte 19.
        res_kind = PH_HEADER;
        res_hoff = hc;
        if (hc == HEADER_LEN_HI) begin
          body_length_next = {iq_byte, bl[7:0]};
        end else if (hc == HEADER_LEN_LO) begin
          body_length_next = {bl[15:8], iq_byte};
        end
        if (hc >= HEADER_LAST) begin
          header_count_next = '0;
          field_count_next  = '0;
          if (body_length_next == 16'd0) begin
            res_mdone  = 1'b1;
            phase_next = PH_OUTSIDE;
          end else begin
            phase_next = PH_TYPE;
          end
        end else begin
          header_count_next = hc + 5'd1;
        end
        res_msg_len = body_length_next;
      end
      PH_TYPE, PH_LENGTH, PH_VALUE, PH_PAD: begin
        body_consumed_next = consumed[15:0];
        res_kind = ph;
        case (ph)
          PH_TYPE: begin
            // Two type bytes, high byte first.
            if (fc == 16'd0) begin
              current_type_next   = {iq_byte, 8'h00};
              current_length_next = '0;
              overrun_seen_next   = 1'b0;
              type_known          = 1'b0;
              field_count_next    = 16'd1;
            end else begin
              current_type_next = ct | {8'h00, iq_byte};
              field_count_next  = '0;
              phase_next        = PH_LENGTH;
            end
          end
          PH_LENGTH: begin
            // Two length bytes; the second checks the padded end
            // against the body length.
            if (fc == 16'd0) begin
              current_length_next = {iq_byte, 8'h00};
              field_count_next    = 16'd1;
            end else begin
              current_length_next = cl | {8'h00, iq_byte};
              field_count_next    = '0;
              reach = {1'b0, consumed} + {1'b0, padded_len(current_length_next)};
              if (reach > {2'b00, bl}) begin
                overrun_seen_next = 1'b1;
              end
              if (current_length_next == 16'd0) begin
                res_adone = 1'b1;
              end else begin
                phase_next = PH_VALUE;
              end
            end
          end
          PH_VALUE: begin
            // Value bytes, then padding if the length is not aligned.
            res_voff         = fc;
            field_count_next = fc_inc[15:0];
            if (fc_inc >= {1'b0, cl}) begin
              if (cl[1:0] != 2'b00) begin
                phase_next = PH_PAD;
              end else begin
                res_adone = 1'b1;
              end
            end
          end
          default: begin
            // Padding bytes up to the 4-byte boundary.
            res_voff         = fc;
            field_count_next = fc_inc[15:0];
            if (fc_inc >= padded_len(cl)) begin
              res_adone = 1'b1;
            end
          end
        endcase

        // A finished attribute starts the next one.
        if (res_adone) begin
          phase_next       = PH_TYPE;
          field_count_next = '0;
          if (ac != 8'hFF) begin
            attribute_count_next = ac + 8'd1;
          end
        end

        // The declared body length ends the message, whole or not.
        if (consumed >= {1'b0, bl}) begin
          res_mdone = 1'b1;
          if (!res_adone) begin
            overrun_seen_next = 1'b1;
          end
          phase_next = PH_OUTSIDE;
        end

        res_index   = ac;
        res_type    = current_type_next;
        res_len     = current_length_next;
        res_match   = type_known && (current_type_next == watch_attr_type);
        res_msg_len = bl;
        res_overrun = overrun_seen_next;
      end
      default: begin
        // No message in progress: report the byte and change nothing.
        phase_next = PH_OUTSIDE;
        res_kind   = PH_OUTSIDE;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= iq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      byte_kind      <= res_kind;
      header_offset  <= res_hoff;
      attr_index     <= res_index;
      attr_kind      <= res_type;
      attr_length    <= res_len;
      value_offset   <= res_voff;
      byte_out       <= iq_byte;
      type_match     <= res_match;
      message_length <= res_msg_len;
      attr_done      <= res_adone;
      message_done   <= res_mdone;
      overrun_error  <= res_overrun;
    end
  end

  // Header results never point past the last header byte.
  `STUN_TLV_ASSERT_SAME(a_header_offset_range, clk, rst,
    out_valid && byte_kind == PH_HEADER, header_offset <= HEADER_LAST)

  // A held end-of-message result means the walker has left the message.
  `STUN_TLV_ASSERT_SAME(a_done_leaves_message, clk, rst,
    out_valid && message_done, phase == PH_OUTSIDE)

  // A held end-of-attribute result leaves the walker at a type or outside.
  `STUN_TLV_ASSERT_SAME(a_attr_done_phase, clk, rst,
    out_valid && attr_done, phase == PH_TYPE || phase == PH_OUTSIDE)

  // Header and outside bytes carry no attribute flags.
  `STUN_TLV_ASSERT_SAME(a_no_flags_outside_attr, clk, rst,
    out_valid && (byte_kind == PH_HEADER || byte_kind == PH_OUTSIDE),
    !overrun_error && !type_match && !attr_done)

  // A start byte puts the walker on header byte 1.
  `STUN_TLV_ASSERT_NEXT(a_start_enters_header, clk, rst,
    step && iq_start, phase == PH_HEADER && header_count == 5'd1)

endmodule

@@ bench/tb_stun_attribute_tlv_parser.sv @@
// Self-checking testbench for the STUN attribute parser: byte walker predictor and tag scoreboard.
module tb_stun_attribute_tlv_parser;
  import stun_tlv_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES = 150;
  localparam int RANDOM_BYTES = 160;
  localparam int SAT_ATTRS = 258;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [PADDR_W-1:0] WATCH_ADDR = {REG_WATCH_ATTR_TYPE, 2'b00};
  localparam logic [PADDR_W-1:0] UNUSED_ADDR = 3'd4;

  // Expected tags for one byte.
  typedef struct packed {
    phase_t      kind;
    logic [4:0]  hoff;
    logic [7:0]  idx;
    logic [15:0] akind;
    logic [15:0] alen;
    logic [15:0] voff;
    logic [7:0]  data;
    logic        match;
    logic [15:0] mlen;
    logic        adone;
    logic        mdone;
    logic        ovr;
  } tag_t;

  // One byte request as queued by the message builder.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } stim_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid;
  logic                in_stall;
  logic [7:0]          data_byte;
  logic                start_message;
  logic                out_valid;
  logic                out_stall;
  logic [2:0]          byte_kind;
  logic [4:0]          header_offset;
  logic [7:0]          attr_index;
  logic [15:0]         attr_kind;
  logic [15:0]         attr_length;
  logic [15:0]         value_offset;
  logic [7:0]          byte_out;
  logic                type_match;
  logic [15:0]         message_length;
  logic                attr_done;
  logic                message_done;
  logic                overrun_error;

  // Walker model state and the watch register copy.
  phase_t      ph;
  logic [4:0]  hdr_cnt;
  logic [15:0] body_len;
  logic [15:0] body_used;
  logic [15:0] cur_type;
  logic [15:0] cur_len;
  logic [15:0] fld_cnt;
  logic [7:0]  attr_cnt;
  logic        ovr_seen;
  logic [15:0] watch_type;

  tag_t  tag_q[$];
  stim_t stim_q[$];
  tag_t  want;
  int    errors;
  int    bytes_sent;
  int    tags_checked;
  int    msgs_ended;
  int    watch_settings;
  int    cycles;
  int    hold_req;
  int    hold_seen;
  int    hold_count;
  bit    quiet;

  stun_attribute_tlv_parser i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .start_message (start_message),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .byte_kind     (byte_kind),
    .header_offset (header_offset),
    .attr_index    (attr_index),
    .attr_kind     (attr_kind),
    .attr_length   (attr_length),
    .value_offset  (value_offset),
    .byte_out      (byte_out),
    .type_match    (type_match),
    .message_length(message_length),
    .attr_done     (attr_done),
    .message_done  (message_done),
    .overrun_error (overrun_error)
  );

  // Clock with an 8-unit period.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Cycle counter that ends a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Value length rounded up to a whole word.
  function automatic int pad4(input int n);
    return ((n + 3) / 4) * 4;
  endfunction

  // Drops all message state, as on reset or a new message.
  function automatic void clear_walk();
    hdr_cnt = '0;
    body_len = '0;
    body_used = '0;
    cur_type = '0;
    cur_len = '0;
    fld_cnt = '0;
    attr_cnt = '0;
    ovr_seen = 1'b0;
  endfunction

  // Advances the walker model by one byte and returns the tags it carries.
  function automatic tag_t tag_byte(input logic [7:0] b, input logic s);
    tag_t r;
    int used;
    int fc;
    int voff;
    bit adone;
    bit known;
    logic [7:0] idx_now;
    r = '0;
    adone = 1'b0;
    known = 1'b1;
    voff = 0;
    if (s) begin
      clear_walk();
      ph = PH_HEADER;
    end
    r.data = b;
    case (ph)
      PH_HEADER: begin
        r.kind = PH_HEADER;
        r.hoff = hdr_cnt;
        if (hdr_cnt == HEADER_LEN_HI) body_len[15:8] = b;
        else if (hdr_cnt == HEADER_LEN_LO) body_len[7:0] = b;
        if (hdr_cnt >= HEADER_LAST) begin
          hdr_cnt = '0;
          fld_cnt = '0;
          if (body_len == 16'd0) begin
            r.mdone = 1'b1;
            ph = PH_OUTSIDE;
          end else begin
            ph = PH_TYPE;
          end
        end else begin
          hdr_cnt = hdr_cnt + 5'd1;
        end
        r.mlen = body_len;
      end
      PH_TYPE, PH_LENGTH, PH_VALUE, PH_PAD: begin
        used = int'(body_used) + 1;
        body_used = used[15:0];
        fc = int'(fld_cnt);
        idx_now = attr_cnt;
        r.kind = ph;
        case (ph)
          PH_TYPE: begin
            if (fc == 0) begin
              cur_type = {b, 8'h00};
              cur_len = '0;
              ovr_seen = 1'b0;
              known = 1'b0;
              fld_cnt = 16'd1;
            end else begin
              cur_type = cur_type | {8'h00, b};
              fld_cnt = '0;
              ph = PH_LENGTH;
            end
          end
          PH_LENGTH: begin
            if (fc == 0) begin
              cur_len = {b, 8'h00};
              fld_cnt = 16'd1;
            end else begin
              cur_len = cur_len | {8'h00, b};
              fld_cnt = '0;
              if (used + pad4(int'(cur_len)) > int'(body_len)) ovr_seen = 1'b1;
              if (cur_len == 16'd0) adone = 1'b1;
              else ph = PH_VALUE;
            end
          end
          PH_VALUE: begin
            voff = fc;
            fc = fc + 1;
            fld_cnt = fc[15:0];
            if (fc >= int'(cur_len)) begin
              if (cur_len[1:0] != 2'b00) ph = PH_PAD;
              else adone = 1'b1;
            end
          end
          default: begin
            voff = fc;
            fc = fc + 1;
            fld_cnt = fc[15:0];
            if (fc >= pad4(int'(cur_len))) adone = 1'b1;
          end
        endcase
        // A finished attribute moves on to the next type field.
        if (adone) begin
          ph = PH_TYPE;
          fld_cnt = '0;
          if (attr_cnt < 8'd255) attr_cnt = attr_cnt + 8'd1;
        end
        // The declared body length ends the message whatever the attribute state.
        if (used >= int'(body_len)) begin
          r.mdone = 1'b1;
          if (!adone) ovr_seen = 1'b1;
          ph = PH_OUTSIDE;
        end
        r.idx = idx_now;
        r.akind = cur_type;
        r.alen = cur_len;
        r.voff = voff[15:0];
        r.match = known && (cur_type == watch_type);
        r.mlen = body_len;
        r.adone = adone;
        r.ovr = ovr_seen;
      end
      default: begin
        ph = PH_OUTSIDE;
        r.kind = PH_OUTSIDE;
        r.mlen = body_len;
      end
    endcase
    return r;
  endfunction

  // Result receiver: random stalls, quiet stretches and long hold-offs on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_count <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_count <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_count > 0) begin
      hold_count <= hold_count - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 18);
    end
  end

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  // Scoreboard: each accepted result against the oldest expected tag.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (tag_q.size() == 0) begin
        $display("%0t: result with no request pending, byte %0h", $time, byte_out);
        errors++;
      end else begin
        want = tag_q.pop_front();
        check_field("byte_kind", {13'd0, want.kind}, {13'd0, byte_kind});
        check_field("header_offset", {11'd0, want.hoff}, {11'd0, header_offset});
        check_field("attr_index", {8'd0, want.idx}, {8'd0, attr_index});
        check_field("attr_kind", want.akind, attr_kind);
        check_field("attr_length", want.alen, attr_length);
        check_field("value_offset", want.voff, value_offset);
        check_field("byte_out", {8'd0, want.data}, {8'd0, byte_out});
        check_field("type_match", {15'd0, want.match}, {15'd0, type_match});
        check_field("message_length", want.mlen, message_length);
        check_field("attr_done", {15'd0, want.adone}, {15'd0, attr_done});
        check_field("message_done", {15'd0, want.mdone}, {15'd0, message_done});
        check_field("overrun_error", {15'd0, want.ovr}, {15'd0, overrun_error});
        tags_checked++;
        if (want.mdone) msgs_ended++;
      end
    end
  end

  // Offers one byte request and records its expected tags once accepted.
  task automatic send_byte(input logic [7:0] b, input logic s);
    while (!quiet && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    start_message <= s;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    tag_q.push_back(tag_byte(b, s));
    bytes_sent++;
  endtask

  task automatic play_stim();
    foreach (stim_q[i]) send_byte(stim_q[i].data, stim_q[i].start);
    stim_q.delete();
  endtask

  // Stops offering and waits until every expected result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tag_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == WATCH_ADDR) watch_type = data[15:0];
  endtask

  // Sets the watch type while idle, plus a write to an unused index.
  task automatic configure(input logic [15:0] wt);
    drain();
    apb_write(WATCH_ADDR, {16'($urandom), wt});
    apb_write(UNUSED_ADDR, $urandom);
    watch_settings++;
  endtask

  task automatic put_byte(input logic [7:0] b, input logic s);
    stim_t e;
    e.data = b;
    e.start = s;
    stim_q.push_back(e);
  endtask

  task automatic put_noise(input int n);
    repeat (n) put_byte(8'($urandom), 1'b0);
  endtask

  // Twenty header bytes with the body length at positions 2 and 3.
  task automatic put_header(input logic [15:0] len);
    put_byte(8'($urandom), 1'b1);
    put_byte(8'($urandom), 1'b0);
    put_byte(len[15:8], 1'b0);
    put_byte(len[7:0], 1'b0);
    put_noise(16);
  endtask

  task automatic put_attr(input logic [15:0] t, input logic [15:0] len, input int nval);
    put_byte(t[15:8], 1'b0);
    put_byte(t[7:0], 1'b0);
    put_byte(len[15:8], 1'b0);
    put_byte(len[7:0], 1'b0);
    put_noise(nval);
  endtask

  // Attribute types biased toward the watch value and its neighbors.
  function automatic logic [15:0] pick_type();
    int r;
    r = $urandom_range(9);
    if (r < 4) return watch_type;
    if (r == 4) return watch_type ^ (16'd1 << $urandom_range(15));
    if (r == 5) return 16'h0000;
    if (r == 6) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Mostly well-formed messages; some truncated, overlong, cut short or after noise.
  task automatic random_message();
    logic [15:0] types[8];
    logic [15:0] lens[8];
    int n_attr;
    int body;
    int declared;
    int shape;
    int cut;
    n_attr = $urandom_range(5);
    body = 0;
    for (int i = 0; i < n_attr; i++) begin
      types[i] = pick_type();
      lens[i] = ($urandom_range(39) == 0) ? 16'($urandom_range(300, 13))
                                          : 16'($urandom_range(12));
      body += 4 + pad4(int'(lens[i]));
    end
    shape = $urandom_range(9);
    declared = body;
    if (shape == 6 && body > 0) declared = body - $urandom_range(body, 1);
    if (shape == 7)
      declared = ($urandom_range(3) == 0) ? 65535 : body + $urandom_range(12, 1);
    if (shape == 9) put_noise($urandom_range(6, 1));
    put_header(declared[15:0]);
    for (int i = 0; i < n_attr; i++) put_attr(types[i], lens[i], pad4(int'(lens[i])));
    if (shape == 8) begin
      cut = $urandom_range(stim_q.size() - 1, 1);
      stim_q = stim_q[0:cut-1];
    end
    if ($urandom_range(7) == 0) put_noise($urandom_range(4, 1));
    play_stim();
  endtask

  // Bytes with no message in progress.
  task automatic test_outside_bytes();
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    play_stim();
  endtask

  // Header with an empty body ends the message on its last byte.
  task automatic test_empty_body();
    put_header(16'h0000);
    put_noise(1);
    play_stim();
  endtask

  // Empty, padded and exact attributes, then one far too long and truncated.
  task automatic test_attr_shapes();
    configure(16'h0001);
    put_header(16'd30);
    put_attr(16'h0001, 16'd0, 0);
    put_attr(16'h0001, 16'd5, 8);
    put_attr(16'hFFFF, 16'd4, 4);
    put_attr(16'h0000, 16'hFFFF, 2);
    put_noise(1);
    play_stim();
  endtask

  // A new message start in the middle of an attribute length.
  task automatic test_restart();
    put_header(16'd8);
    put_attr(16'h0001, 16'd4, 4);
    stim_q = stim_q[0:22];
    put_header(16'h0000);
    play_stim();
  endtask

  // Enough empty attributes to saturate the attribute ordinal, with no idling.
  task automatic test_index_saturation();
    quiet = 1'b1;
    put_header(16'(SAT_ATTRS * 4));
    repeat (SAT_ATTRS) put_attr(pick_type(), 16'd0, 0);
    play_stim();
    quiet = 1'b0;
  endtask

  // Long receiver hold-off while the sender keeps offering, then a full pause.
  task automatic test_backpressure();
    hold_req++;
    put_header(16'd48);
    repeat (4) put_attr(pick_type(), 16'd8, 8);
    play_stim();
    drain();
  endtask

  task automatic test_random_messages();
    int first;
    for (int p = 0; p < 4; p++) begin
      if (p == 0) configure(16'hFFFF);
      else if (p == 1) configure(16'h0000);
      else configure(16'($urandom));
      quiet = (p == 2);
      first = bytes_sent;
      while (bytes_sent - first < RANDOM_BYTES / 4) random_message();
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    data_byte <= '0;
    start_message <= 1'b0;
    cycles = 0;
    errors = 0;
    bytes_sent = 0;
    tags_checked = 0;
    msgs_ended = 0;
    watch_settings = 0;
    hold_req = 0;
    quiet = 1'b0;
    clear_walk();
    ph = PH_OUTSIDE;
    watch_type = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_outside_bytes();
    test_empty_body();
    test_attr_shapes();
    test_restart();
    test_backpressure();
    test_index_saturation();
    test_random_messages();
    drain();

    $display("summary: %0d bytes sent, %0d results checked, %0d messages ended",
             bytes_sent, tags_checked, msgs_ended);
    $display("summary: %0d watch type settings, %0d mismatches", watch_settings, errors);
    if (errors == 0 && tag_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
